// ----- sv/dcfp_pkg.sv -----
// Shared types and constants for the display command frame parser.
// Depends on nothing; imported by every module of the block.
package dcfp_pkg;

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int FONT_W  = 2;
    localparam int POS_W   = 4;
    localparam int HDR_W   = 16;

    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CHAR  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

    localparam logic [BYTE_W-1:0] CHAR_F    = 8'h46;
    localparam logic [BYTE_W-1:0] CHAR_E    = 8'h45;
    localparam logic [BYTE_W-1:0] CHAR_D    = 8'h44;
    localparam logic [BYTE_W-1:0] CHAR_L    = 8'h4C;
    localparam logic [BYTE_W-1:0] CHAR_PLUS = 8'h2B;
    localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;

    localparam logic [FONT_W-1:0] FONT_MAX  = 2'd2;

    // body byte positions, and the last header byte position
    localparam logic [POS_W-1:0] POS_PLUS    = 4'd0;
    localparam logic [POS_W-1:0] POS_COL_HI  = 4'd1;
    localparam logic [POS_W-1:0] POS_COL_LO  = 4'd2;
    localparam logic [POS_W-1:0] POS_LINE_HI = 4'd3;
    localparam logic [POS_W-1:0] POS_LINE_LO = 4'd4;
    localparam logic [POS_W-1:0] POS_FONT    = 4'd5;
    localparam logic [POS_W-1:0] POS_CNT_HI  = 4'd6;
    localparam logic [POS_W-1:0] POS_CNT_LO  = 4'd7;
    localparam logic [POS_W-1:0] POS_HDR_END = 4'd2;

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_BODY   = 3'b010,
        PH_TEXT   = 3'b100
    } phase_t;

    typedef struct packed {
        logic [KIND_W-1:0] cmd_kind;
        logic [BYTE_W-1:0] cursor_x;
        logic [BYTE_W-1:0] cursor_y;
        logic [FONT_W-1:0] font_sel;
        logic [BYTE_W-1:0] char_code;
        logic [BYTE_W-1:0] char_index;
        logic              last_char;
    } result_t;

    typedef struct packed {
        logic       full;
        logic [1:0] level;
    } buf_status_t;

endpackage

// ----- sv/display_command_frame_parser_top.sv -----
// Display command frame parser, top level: input register, parser, result buffer.
// Depends on dcfp_pkg, dcfp_parse and dcfp_out_buf.
//
// Usage:
//   Input channel rx_valid / rx_stall / rx_byte carries one received byte per
//   transfer. Output channel out_valid / out_stall carries one command result
//   per transfer (cmd_kind, cursor, font, character, index, last flag).
//   A byte is taken into the input register, parsed from there while the
//   two-entry output buffer is not full, and its result, if any, is written
//   into that buffer, from which it is offered on the output channel.
//   Throughput: one byte per cycle, set by the single parse step per cycle
//   and the output buffer never filling while the receiver keeps up.
//   When the receiver stalls, results queue in the output buffer; once it
//   holds two, parsing halts and rx_stall rises while a byte waits in the
//   input register.
//   Reset clears the parser to the header phase and empties both the input
//   register and the output buffer.
module display_command_frame_parser_top
    import dcfp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rx_valid,
    output logic              rx_stall,
    input  logic [BYTE_W-1:0] rx_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [KIND_W-1:0] cmd_kind,
    output logic [BYTE_W-1:0] cursor_x,
    output logic [BYTE_W-1:0] cursor_y,
    output logic [FONT_W-1:0] font_sel,
    output logic [BYTE_W-1:0] char_code,
    output logic [BYTE_W-1:0] char_index,
    output logic              last_char
);

    logic              in_vld_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              fire;
    logic              res_valid;
    result_t           res;
    result_t           head;
    buf_status_t       buf_status;

    assign fire     = in_vld_reg && !buf_status.full;
    assign rx_stall = in_vld_reg && !fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (!rx_stall)
        begin
            in_vld_reg <= rx_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_valid && !rx_stall)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    dcfp_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (fire),
        .rx_byte   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    dcfp_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire && res_valid),
        .push_data (res),
        .status    (buf_status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign cmd_kind   = head.cmd_kind;
    assign cursor_x   = head.cursor_x;
    assign cursor_y   = head.cursor_y;
    assign font_sel   = head.font_sel;
    assign char_code  = head.char_code;
    assign char_index = head.char_index;
    assign last_char  = head.last_char;

`ifndef NO_ASSERTIONS
    a_held_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !fire) |=> (in_vld_reg && $stable(in_byte_reg)))
        else $error("waiting input byte lost or changed");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        buf_status.level != 2'd3)
        else $error("result buffer overfilled");

    a_clear_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res_valid && res.cmd_kind == KIND_CLEAR) |->
        (res.cursor_x == '0 && res.cursor_y == '0 && res.font_sel == '0 && res.last_char))
        else $error("clear command with nonzero fields");

    a_non_char_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && cmd_kind != KIND_CHAR) |-> (last_char && char_code == '0))
        else $error("non-character result without last flag");
`endif

endmodule

// ----- sv/dcfp_parse.sv -----
// Frame parsing state machine: consumes one byte per enable, forms results.
// Depends on dcfp_pkg.
module dcfp_parse
    import dcfp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic [BYTE_W-1:0] rx_byte,
    output logic              res_valid,
    output result_t           res
);

    phase_t            phase_reg, phase_next;
    logic [POS_W-1:0]  byte_pos_reg, byte_pos_next;
    logic [HDR_W-1:0]  header_reg, header_next;
    logic [BYTE_W-1:0] tens_reg, tens_next;
    logic [BYTE_W-1:0] held_x_reg, held_x_next;
    logic [BYTE_W-1:0] held_y_reg, held_y_next;
    logic [FONT_W-1:0] held_font_reg, held_font_next;
    logic [BYTE_W-1:0] text_left_reg, text_left_next;
    logic [BYTE_W-1:0] text_pos_reg, text_pos_next;

    logic [BYTE_W-1:0] digit;
    logic [BYTE_W-1:0] pair;
    logic [BYTE_W-1:0] tens;
    logic              last;

    assign digit = rx_byte - CHAR_ZERO;
    assign pair  = tens_reg + digit;
    assign tens  = {digit[4:0], 3'b000} + {digit[6:0], 1'b0};
    assign last  = (text_left_reg == 8'd1);

    always_comb
    begin
        phase_next     = phase_reg;
        byte_pos_next  = byte_pos_reg;
        header_next    = header_reg;
        tens_next      = tens_reg;
        held_x_next    = held_x_reg;
        held_y_next    = held_y_reg;
        held_font_next = held_font_reg;
        text_left_next = text_left_reg;
        text_pos_next  = text_pos_reg;
        res_valid      = 1'b0;
        res            = '0;
        unique case (phase_reg)
            PH_BODY:
            begin
                case (byte_pos_reg)
                    POS_PLUS:    header_next = {8'h00, rx_byte};
                    POS_COL_HI,
                    POS_LINE_HI,
                    POS_CNT_HI:  tens_next = tens;
                    POS_COL_LO:  held_y_next = pair;
                    POS_LINE_LO: held_x_next = pair;
                    POS_FONT:    held_font_next = (digit <= {6'd0, FONT_MAX}) ?
                                                  digit[FONT_W-1:0] : '0;
                    default:     text_left_next = pair;
                endcase
                if (byte_pos_reg < POS_CNT_LO)
                begin
                    byte_pos_next = byte_pos_reg + 4'd1;
                end
                else
                begin
                    byte_pos_next = '0;
                    text_pos_next = '0;
                    header_next   = '0;
                    if (header_reg != {8'h00, CHAR_PLUS})
                    begin
                        phase_next = PH_HEADER;
                    end
                    else if (pair == 8'd0)
                    begin
                        phase_next         = PH_HEADER;
                        res_valid          = 1'b1;
                        res.cmd_kind       = KIND_EMPTY;
                        res.cursor_x       = held_x_reg;
                        res.cursor_y       = held_y_reg;
                        res.font_sel       = held_font_reg;
                        res.last_char      = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_TEXT;
                    end
                end
            end
            PH_TEXT:
            begin
                res_valid      = 1'b1;
                res.cmd_kind   = KIND_CHAR;
                res.cursor_x   = held_x_reg;
                res.cursor_y   = held_y_reg;
                res.font_sel   = held_font_reg;
                res.char_code  = rx_byte;
                res.char_index = text_pos_reg;
                res.last_char  = last;
                text_pos_next  = text_pos_reg + 8'd1;
                text_left_next = text_left_reg - 8'd1;
                if (last)
                begin
                    phase_next = PH_HEADER;
                end
            end
            default:
            begin
                phase_next = PH_HEADER;
                if (byte_pos_reg < POS_HDR_END)
                begin
                    header_next   = {header_reg[7:0], rx_byte};
                    byte_pos_next = byte_pos_reg + 4'd1;
                end
                else
                begin
                    byte_pos_next = '0;
                    header_next   = '0;
                    if (header_reg[15:8] == CHAR_F && header_reg[7:0] == CHAR_E &&
                        rx_byte == CHAR_E)
                    begin
                        phase_next = PH_BODY;
                    end
                    else if (header_reg[15:8] == CHAR_D && header_reg[7:0] == CHAR_E &&
                             rx_byte == CHAR_L)
                    begin
                        res_valid     = 1'b1;
                        res.cmd_kind  = KIND_CLEAR;
                        res.last_char = 1'b1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            byte_pos_reg  <= '0;
            header_reg    <= '0;
            tens_reg      <= '0;
            held_x_reg    <= '0;
            held_y_reg    <= '0;
            held_font_reg <= '0;
            text_left_reg <= '0;
            text_pos_reg  <= '0;
        end
        else if (en)
        begin
            phase_reg     <= phase_next;
            byte_pos_reg  <= byte_pos_next;
            header_reg    <= header_next;
            tens_reg      <= tens_next;
            held_x_reg    <= held_x_next;
            held_y_reg    <= held_y_next;
            held_font_reg <= held_font_next;
            text_left_reg <= text_left_next;
            text_pos_reg  <= text_pos_next;
        end
    end

endmodule

// ----- sv/dcfp_out_buf.sv -----
// Two-entry result buffer between the parser and the output channel.
// Depends on dcfp_pkg.
module dcfp_out_buf
    import dcfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  result_t     push_data,
    output buf_status_t status,
    output logic        out_valid,
    input  logic        out_stall,
    output result_t     head
);

    logic [1:0] level_reg, level_next;
    result_t    slot0_reg;
    result_t    slot1_reg;
    logic       pop;

    assign pop         = out_valid && !out_stall;
    assign out_valid   = (level_reg != 2'd0);
    assign head        = slot0_reg;
    assign status.full  = (level_reg == 2'd2);
    assign status.level = level_reg;

    always_comb
    begin
        level_next = level_reg;
        case ({push, pop})
            2'b10:   level_next = level_reg + 2'd1;
            2'b01:   level_next = level_reg - 2'd1;
            default: level_next = level_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
        end
        else
        begin
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case ({push, pop})
            2'b10:
            begin
                if (level_reg == 2'd0)
                begin
                    slot0_reg <= push_data;
                end
                else
                begin
                    slot1_reg <= push_data;
                end
            end
            2'b01:
            begin
                slot0_reg <= slot1_reg;
            end
            2'b11:
            begin
                if (level_reg == 2'd1)
                begin
                    slot0_reg <= push_data;
                end
                else
                begin
                    slot0_reg <= slot1_reg;
                    slot1_reg <= push_data;
                end
            end
            default:
            begin
                slot0_reg <= slot0_reg;
            end
        endcase
    end

endmodule
